// File: rtl/core/sks_pkg.sv
// ----------------------------------------------------------------------------
// sks_pkg
// Shared types and constants for the sorted key set: the request and response
// items, the operation and status codes and the control bundle to the cells.
// ----------------------------------------------------------------------------
package sks_pkg;

    // store geometry
    localparam int CAPACITY  = 16;
    localparam int KEY_WIDTH = 32;

    // field widths of the response item
    localparam int POS_W = 4;
    localparam int CNT_W = 5;

    // operation codes
    typedef enum logic [1:0] {
        CMD_SEARCH = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    // result codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_DUP  = 2'd2,
        ST_FULL = 2'd3
    } status_t;

    // request item
    typedef struct packed {
        cmd_t                        cmd;
        logic signed [KEY_WIDTH-1:0] key;
    } req_t;

    // response item
    typedef struct packed {
        status_t            status;
        logic [POS_W-1:0]   position;
        logic [CNT_W-1:0]   count;
    } rsp_t;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic                        ins;
        logic                        del;
        logic signed [KEY_WIDTH-1:0] key;
    } cell_ctl_t;

endpackage

// File: rtl/core/sks_cell.sv
// ----------------------------------------------------------------------------
// sks_cell
// One slot of the sorted store. Compares its key with the broadcast key and
// takes its neighbour's key when an insert or delete shifts the row.
// ----------------------------------------------------------------------------
module sks_cell
    import sks_pkg::*;
(
    input  logic                        clk,
    input  cell_ctl_t                   ctl,
    input  logic                        occupied,
    input  logic                        left_lt,
    input  logic signed [KEY_WIDTH-1:0] lower_key,
    input  logic signed [KEY_WIDTH-1:0] upper_key,
    output logic signed [KEY_WIDTH-1:0] key,
    output logic                        lt,
    output logic                        eq
);

    logic signed [KEY_WIDTH-1:0] key_reg;
    logic signed [KEY_WIDTH-1:0] key_next;

    // compare against the broadcast key
    assign lt  = occupied && (key_reg < ctl.key);
    assign eq  = occupied && (key_reg == ctl.key);
    assign key = key_reg;

    // shift up on insert, down on delete, else hold
    always_comb
    begin
        key_next = key_reg;
        if (ctl.ins)
        begin
            if (!left_lt)
            begin
                key_next = lower_key;
            end
            else if (!lt)
            begin
                key_next = ctl.key;
            end
        end
        else if (ctl.del)
        begin
            if (!lt)
            begin
                key_next = upper_key;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

// File: rtl/core/sks_out_buf.sv
// ----------------------------------------------------------------------------
// sks_out_buf
// Two-entry response buffer: an output register and a skid register, so a
// new item is taken while a finished response waits on a stalled receiver.
// ----------------------------------------------------------------------------
module sks_out_buf
    import sks_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic load,
    input  rsp_t din,
    input  logic rsp_stall,
    output logic rsp_valid,
    output rsp_t rsp,
    output logic full
);

    logic main_valid_reg;
    logic main_valid_next;
    rsp_t main_reg;
    rsp_t main_next;
    logic skid_valid_reg;
    logic skid_valid_next;
    rsp_t skid_reg;
    rsp_t skid_next;
    logic take;

    assign take      = main_valid_reg && !rsp_stall;
    assign rsp_valid = main_valid_reg;
    assign rsp       = main_reg;
    assign full      = skid_valid_reg;

    // buffer steering
    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_next       = main_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (load)
        begin
            if (main_valid_reg && !take)
            begin
                skid_next       = din;
                skid_valid_next = 1'b1;
            end
            else
            begin
                main_next       = din;
                main_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            main_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

// File: rtl/core/sorted_key_set.sv
// ----------------------------------------------------------------------------
// sorted_key_set
// Set of distinct signed keys kept in ascending order in a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_valid, req_stall, req) carries an operation
//   (search, insert, delete, clear) and a key. The response channel
//   (rsp_valid, rsp_stall, rsp) returns one item per request: status,
//   sorted position and the count after the operation.
//   Every cell compares its key with the request key in the same cycle and
//   takes its neighbour's key on a shift, so one request is done per cycle
//   while req_stall is low. The response is registered in the output buffer;
//   throughput is one item per cycle while the receiver does not stall.
//   A two-entry response buffer lets one more request in while a response
//   is stalled; req_stall rises once both entries are occupied.
//   Reset empties the set (count zero) and drops buffered responses; key
//   cells are not cleared, as only the first count cells are ever compared.
// ----------------------------------------------------------------------------
module sorted_key_set
    import sks_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    logic                        accept;
    logic                        buf_full;
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    cell_ctl_t                   ctl;
    logic signed [KEY_WIDTH-1:0] cell_key [CAPACITY];
    logic [CAPACITY-1:0]         cell_lt;
    logic [CAPACITY-1:0]         cell_eq;
    logic [CAPACITY-1:0]         boundary;
    logic [POS_W-1:0]            idx;
    logic                        hit;
    logic                        is_full;
    rsp_t                        result;

    assign req_stall = buf_full;
    assign accept    = req_valid && !buf_full;
    assign hit       = |cell_eq;
    assign is_full   = (count_reg == CNT_W'(CAPACITY));

    // row of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                        occ;
        logic                        left;
        logic signed [KEY_WIDTH-1:0] lower;
        logic signed [KEY_WIDTH-1:0] upper;

        assign occ = (count_reg > CNT_W'(i));

        if (i == 0)
        begin : g_first
            assign left  = 1'b1;
            assign lower = req.key;
        end
        else
        begin : g_mid
            assign left  = cell_lt[i-1];
            assign lower = cell_key[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign upper = cell_key[i];
        end
        else
        begin : g_inner
            assign upper = cell_key[i+1];
        end

        assign boundary[i] = left && !cell_lt[i];

        sks_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .occupied  (occ),
            .left_lt   (left),
            .lower_key (lower),
            .upper_key (upper),
            .key       (cell_key[i]),
            .lt        (cell_lt[i]),
            .eq        (cell_eq[i])
        );
    end

    // sorted index of the first key not below the request key
    always_comb
    begin
        idx = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (boundary[i])
            begin
                idx = idx | POS_W'(i);
            end
        end
    end

    // operation decode, count update and response
    always_comb
    begin
        ctl.ins         = 1'b0;
        ctl.del         = 1'b0;
        ctl.key         = req.key;
        count_next      = count_reg;
        result.status   = ST_OK;
        result.position = '0;
        unique case (req.cmd)
            CMD_SEARCH:
            begin
                if (hit)
                begin
                    result.position = idx;
                end
                else
                begin
                    result.status = ST_MISS;
                end
            end
            CMD_INSERT:
            begin
                if (hit)
                begin
                    result.status = ST_DUP;
                end
                else if (is_full)
                begin
                    result.status = ST_FULL;
                end
                else
                begin
                    ctl.ins         = accept;
                    count_next      = count_reg + CNT_W'(1);
                    result.position = idx;
                end
            end
            CMD_DELETE:
            begin
                if (hit)
                begin
                    ctl.del         = accept;
                    count_next      = count_reg - CNT_W'(1);
                    result.position = idx;
                end
                else
                begin
                    result.status = ST_MISS;
                end
            end
            CMD_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        result.count = count_next;
    end

    // key count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

    // response buffer
    sks_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .din       (result),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .full      (buf_full)
    );

endmodule
